// File: sv/tpq_pkg.sv
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and constants of the timed playout queue: item layouts,
// result kinds, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tpq_pkg;

   // default number of queue entries
   localparam int QUEUE_DEPTH_DEFAULT = 16;

   // nanoseconds in one second (fits in 30 bits)
   localparam logic [29:0] NS_PER_SECOND = 30'd1000000000;

   // reset value of the lateness limit: 40 ms
   localparam logic [31:0] LATENESS_RESET = 32'd40000000;

   // field widths
   localparam int DUE_W    = 63;
   localparam int HANDLE_W = 8;
   localparam int LEVEL_W  = 5;
   localparam int CNT_W    = 32;
   localparam int ENTRY_W  = DUE_W + HANDLE_W;

   // stream widths
   localparam int REQ_DATA_W = 152;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 144;
   localparam int RSP_USER_W = 3;

   // result kinds
   typedef enum logic [2:0] {
      KIND_ACCEPTED  = 3'd0,
      KIND_MALFORMED = 3'd1,
      KIND_LATE      = 3'd2,
      KIND_FULL      = 3'd3,
      KIND_RELEASED  = 3'd4
   } kind_type;

   // input modes
   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_TICK    = 1'b1;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ENQ_MUL,
      ST_ENQ_ADD,
      ST_ENQ_CHECK,
      ST_ENQ_RD,
      ST_ENQ_CMP,
      ST_ENQ_WR,
      ST_TICK_RD,
      ST_TICK_CMP,
      ST_TICK_FLUSH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic     load_in;    // capture accepted input item
      logic     load_due;   // register computed due time
      logic     ins_setup;  // start insertion walk at the tail
      logic     rd_tail;    // read entry ahead of the walk index
      logic     shift_wr;   // move read entry one slot toward the tail
      logic     ins_wr;     // write the new entry, count up
      logic     rd_head;    // read the head entry
      logic     pop;        // take head entry into the pending slot
      logic     emit_new;   // send result about the input frame
      logic     emit_pend;  // send pending release result
      logic     emit_last;  // tlast for the pending release
      logic     late_inc;   // bump the late counter
      kind_type kind;       // kind for emit_new
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic mode;
      logic malformed;
      logic late;
      logic full;
      logic k_zero;
      logic count_zero;
      logic shift_more;
      logic head_due;
      logic out_free;
      logic have_pend;
   } sts_type;

endpackage

`default_nettype wire

// File: sv/tpq_ram.sv
// ----------------------------------------------------------------------------
// tpq_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/tpq_ctrl.sv
// ----------------------------------------------------------------------------
// tpq_ctrl
// Sequencer of the timed playout queue: walks enqueue and tick items
// through the datapath one RAM access at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module tpq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire tpq_pkg::sts_type sts,
   output tpq_pkg::cmd_type      cmd
);
   import tpq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (sts.mode == MODE_TICK) ? ST_TICK_RD : ST_ENQ_MUL;
            end
         end
         ST_ENQ_MUL: state_in = ST_ENQ_ADD;
         ST_ENQ_ADD: state_in = ST_ENQ_CHECK;
         ST_ENQ_CHECK: begin
            if (sts.malformed || sts.late || sts.full) begin
               if (sts.out_free) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_ENQ_RD;
            end
         end
         ST_ENQ_RD: state_in = sts.k_zero ? ST_ENQ_WR : ST_ENQ_CMP;
         ST_ENQ_CMP: state_in = sts.shift_more ? ST_ENQ_RD : ST_ENQ_WR;
         ST_ENQ_WR: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_TICK_RD: begin
            if (sts.count_zero) begin
               state_in = sts.have_pend ? ST_TICK_FLUSH : ST_IDLE;
            end else begin
               state_in = ST_TICK_CMP;
            end
         end
         ST_TICK_CMP: begin
            if (sts.head_due) begin
               if (!sts.have_pend || sts.out_free) begin
                  state_in = ST_TICK_RD;
               end
            end else if (!sts.have_pend || sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_TICK_FLUSH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.kind   = KIND_ACCEPTED;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         ST_ENQ_ADD: cmd.load_due = 1'b1;
         ST_ENQ_CHECK: begin
            if (sts.malformed) begin
               cmd.emit_new = sts.out_free;
               cmd.kind     = KIND_MALFORMED;
            end else if (sts.late) begin
               cmd.emit_new = sts.out_free;
               cmd.late_inc = sts.out_free;
               cmd.kind     = KIND_LATE;
            end else if (sts.full) begin
               cmd.emit_new = sts.out_free;
               cmd.kind     = KIND_FULL;
            end else begin
               cmd.ins_setup = 1'b1;
            end
         end
         ST_ENQ_RD: cmd.rd_tail = !sts.k_zero;
         ST_ENQ_CMP: cmd.shift_wr = sts.shift_more;
         ST_ENQ_WR: begin
            cmd.ins_wr   = sts.out_free;
            cmd.emit_new = sts.out_free;
            cmd.kind     = KIND_ACCEPTED;
         end
         ST_TICK_RD: cmd.rd_head = !sts.count_zero;
         ST_TICK_CMP: begin
            // a due head is popped only once the previous release can leave
            if (sts.head_due) begin
               if (!sts.have_pend || sts.out_free) begin
                  cmd.pop       = 1'b1;
                  cmd.emit_pend = sts.have_pend;
               end
            end else begin
               cmd.emit_pend = sts.have_pend && sts.out_free;
               cmd.emit_last = 1'b1;
            end
         end
         ST_TICK_FLUSH: begin
            cmd.emit_pend = sts.out_free;
            cmd.emit_last = 1'b1;
         end
         default: begin
            cmd        = '0;
            cmd.kind   = KIND_ACCEPTED;
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: sv/tpq_dp.sv
// ----------------------------------------------------------------------------
// tpq_dp
// Datapath of the timed playout queue: input capture, due time arithmetic,
// circular entry store with head and count, counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tpq_dp #(
   parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // fields from bit 0: now_ns, ts_seconds, ts_nanos, frame_bytes, frame_handle
   input  wire logic [tpq_pkg::REQ_DATA_W-1:0]  req_tdata,
   // fields from bit 0: mode, has_timestamp
   input  wire logic [tpq_pkg::REQ_USER_W-1:0]  req_tuser,
   input  wire logic                            csr_valid,
   input  wire logic [tpq_pkg::CNT_W-1:0]       csr_data,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // fields from bit 0: out_handle, out_due_ns, queue_level, late_total,
   // played_total
   output logic      [tpq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // fields from bit 0: kind
   output logic      [tpq_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                                 rsp_tlast,
   input  wire tpq_pkg::cmd_type                cmd,
   output tpq_pkg::sts_type                     sts
);
   import tpq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

   // captured input item
   logic [DUE_W-1:0]    now_ff;
   logic                has_ts_ff;
   logic [31:0]         secs_ff;
   logic [29:0]         nanos_ff;
   logic [15:0]         bytes_ff;
   logic [HANDLE_W-1:0] handle_ff;

   // due time pipeline
   logic [61:0]      prod_ff;
   logic [DUE_W-1:0] due_ff;
   logic [DUE_W-1:0] due_in;

   // queue bookkeeping
   logic [AW-1:0] head_ff;
   logic [CW-1:0] count_ff;
   logic [AW-1:0] idx_ff;
   logic [CW-1:0] k_ff;
   logic [CW:0]   tail_sum;
   logic [AW-1:0] tail_idx;
   logic [AW-1:0] idx_prev;
   logic [AW-1:0] head_next;

   // counters and register
   logic [CNT_W-1:0] late_ff;
   logic [CNT_W-1:0] played_ff;
   logic [CNT_W-1:0] limit_ff;

   // pending release
   logic                pend_ff;
   logic [HANDLE_W-1:0] pend_handle_ff;
   logic [DUE_W-1:0]    pend_due_ff;
   logic [LEVEL_W-1:0]  pend_level_ff;
   logic [CNT_W-1:0]    pend_played_ff;

   // result register
   logic                rsp_valid_ff;
   kind_type            rsp_kind_ff;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic [DUE_W-1:0]    rsp_due_ff;
   logic [LEVEL_W-1:0]  rsp_level_ff;
   logic [CNT_W-1:0]    rsp_late_ff;
   logic [CNT_W-1:0]    rsp_played_ff;
   logic                rsp_last_ff;
   logic                out_free;

   // entry store
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic [ENTRY_W-1:0]  rd_data;
   logic [DUE_W-1:0]    rd_due;

   // input capture
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         has_ts_ff <= req_tuser[1];
         now_ff    <= req_tdata[62:0];
         secs_ff   <= req_tdata[94:63];
         nanos_ff  <= req_tdata[124:95];
         bytes_ff  <= req_tdata[140:125];
         handle_ff <= req_tdata[148:141];
      end
   end

   // due = seconds * 1e9 + nanos, product registered first
   always_ff @(posedge clock) begin
      prod_ff <= 62'(secs_ff) * 62'(NS_PER_SECOND);
   end

   assign due_in = has_ts_ff ? (DUE_W'(prod_ff) + DUE_W'(nanos_ff)) : now_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_due) begin
         due_ff <= due_in;
      end
   end

   // circular index arithmetic
   assign tail_sum  = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
   assign tail_idx  = (tail_sum >= (CW + 1)'(QUEUE_DEPTH)) ?
                      AW'(tail_sum - (CW + 1)'(QUEUE_DEPTH)) : AW'(tail_sum);
   assign idx_prev  = (idx_ff == '0) ? LAST_SLOT : idx_ff - AW'(1);
   assign head_next = (head_ff == LAST_SLOT) ? '0 : head_ff + AW'(1);

   // walk registers
   always_ff @(posedge clock) begin
      if (cmd.ins_setup) begin
         idx_ff <= tail_idx;
         k_ff   <= count_ff;
      end else if (cmd.shift_wr) begin
         idx_ff <= idx_prev;
         k_ff   <= k_ff - CW'(1);
      end
   end

   // queue head and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.ins_wr) begin
         count_ff <= count_ff + CW'(1);
      end else if (cmd.pop) begin
         head_ff  <= head_next;
         count_ff <= count_ff - CW'(1);
      end
   end

   // lateness limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LATENESS_RESET;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   // running counters
   always_ff @(posedge clock) begin
      if (reset) begin
         late_ff   <= '0;
         played_ff <= '0;
      end else begin
         if (cmd.late_inc) begin
            late_ff <= late_ff + CNT_W'(1);
         end
         if (cmd.pop) begin
            played_ff <= played_ff + CNT_W'(1);
         end
      end
   end

   // entry store access
   assign wr_en   = cmd.shift_wr || cmd.ins_wr;
   assign wr_addr = idx_ff;
   assign wr_data = cmd.ins_wr ? {handle_ff, due_ff} : rd_data;
   assign rd_en   = cmd.rd_tail || cmd.rd_head;
   assign rd_addr = cmd.rd_head ? head_ff : idx_prev;
   assign rd_due  = rd_data[DUE_W-1:0];

   tpq_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // pending release slot
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (cmd.pop) begin
         pend_ff <= 1'b1;
      end else if (cmd.emit_pend) begin
         pend_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         pend_handle_ff <= rd_data[ENTRY_W-1:DUE_W];
         pend_due_ff    <= rd_due;
         pend_level_ff  <= LEVEL_W'(count_ff - CW'(1));
         pend_played_ff <= played_ff + CNT_W'(1);
      end
   end

   // result register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_new || cmd.emit_pend) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_pend) begin
         rsp_kind_ff   <= KIND_RELEASED;
         rsp_handle_ff <= pend_handle_ff;
         rsp_due_ff    <= pend_due_ff;
         rsp_level_ff  <= pend_level_ff;
         rsp_late_ff   <= late_ff;
         rsp_played_ff <= pend_played_ff;
         rsp_last_ff   <= cmd.emit_last;
      end else if (cmd.emit_new) begin
         rsp_kind_ff   <= cmd.kind;
         rsp_handle_ff <= handle_ff;
         rsp_due_ff    <= due_ff;
         rsp_level_ff  <= cmd.ins_wr ? LEVEL_W'(count_ff + CW'(1)) : LEVEL_W'(count_ff);
         rsp_late_ff   <= cmd.late_inc ? late_ff + CNT_W'(1) : late_ff;
         rsp_played_ff <= played_ff;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0, rsp_played_ff, rsp_late_ff, rsp_level_ff,
                        rsp_due_ff, rsp_handle_ff};

   // status toward the controller
   always_comb begin
      sts.mode       = req_tuser[0];
      sts.malformed  = (bytes_ff == '0) || bytes_ff[0];
      sts.late       = (({1'b0, due_ff} + 64'(limit_ff)) < {1'b0, now_ff});
      sts.full       = (count_ff == FULL_COUNT);
      sts.k_zero     = (k_ff == '0);
      sts.count_zero = (count_ff == '0);
      sts.shift_more = (rd_due > due_ff);
      sts.head_due   = (rd_due <= now_ff);
      sts.out_free   = out_free;
      sts.have_pend  = pend_ff;
   end

endmodule

`default_nettype wire

// File: sv/timed_playout_queue.sv
// ----------------------------------------------------------------------------
// timed_playout_queue
// Queue of transmit frames sorted by due time, released on playout ticks.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A rejected enqueue (malformed, late or
// queue full) does no walk. An accepted enqueue walks back from the tail
// through the entry RAM (read, then compare and move), moving every queued
// entry whose due time is later than the new frame's one slot toward the
// tail, until an earlier or equal entry or the head ends the walk. A tick
// reads and compares the head entry, one RAM read and one compare per head
// entry, and releases it while it is due. Back-pressure on the result side
// can stall any item. Entries live in a circular RAM with head pointer and
// fill count, so no clearing pass follows reset. Every enqueue yields one
// result; a tick yields one per released frame, the final one with tlast
// set, and none when nothing is due.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_playout_queue #(
   parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request stream
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // fields from bit 0: now_ns, ts_seconds, ts_nanos, frame_bytes, frame_handle
   input  wire logic [tpq_pkg::REQ_DATA_W-1:0] req_tdata,
   // fields from bit 0: mode, has_timestamp
   input  wire logic [tpq_pkg::REQ_USER_W-1:0] req_tuser,
   // response stream, tlast = last
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // fields from bit 0: out_handle, out_due_ns, queue_level, late_total,
   // played_total
   output logic      [tpq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // fields from bit 0: kind
   output logic      [tpq_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                                rsp_tlast,
   // lateness limit write
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [tpq_pkg::CNT_W-1:0]      csr_data
);
   import tpq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   tpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tpq_dp #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .cmd       (cmd),
      .sts       (sts)
   );

`ifndef SYNTH
   // one item at a time: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while previous item still in work");

   // only releases can be followed by more results of the same item
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tuser == KIND_RELEASED))
      else $error("non-final result that is not a release");

   // result kind is always a defined code
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= KIND_RELEASED))
      else $error("undefined result kind");

   // pop and insert never happen together
   a_no_pop_ins: assert property (@(posedge clock) disable iff (reset)
      !(cmd.pop && cmd.ins_wr))
      else $error("pop and insert in the same cycle");
`endif

endmodule

`default_nettype wire

// File: verif/timed_playout_queue_tb.sv
// ----------------------------------------------------------------------------
// timed_playout_queue_tb
// Self-checking bench for the timed playout queue. Request items (enqueues
// and playout ticks) are driven on the req_ stream and the lateness limit is
// rewritten between phases on the csr_ channel. A scoreboard keeps its own
// sorted copy of the queue and the counters, predicts every result item, and
// compares what arrives on the rsp_ stream in order. Both streams idle and
// stall at random.
// ----------------------------------------------------------------------------
module timed_playout_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tpq_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH_DEFAULT;
   localparam longint unsigned NS_SEC = 64'd1000000000;
   // latest due time a seconds/nanoseconds stamp can express in range
   localparam longint unsigned TS_MAX = 64'd4294967295 * NS_SEC + 64'd999999999;
   localparam logic [62:0] NOW_MAX = '1;
   localparam int CYCLE_LIMIT = 2000000;
   // settle time for the longest enqueue walk, with some margin
   localparam int SETTLE_CYCLES = 48;
   localparam int PHASE_ITEMS = 66;

   // one request item
   typedef struct packed {
      logic        mode;
      logic [62:0] now;
      logic        has_ts;
      logic [31:0] secs;
      logic [29:0] nanos;
      logic [15:0] bytes;
      logic [7:0]  handle;
   } req_item_type;

   // one result item
   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  handle;
      logic [62:0] due;
      logic [4:0]  level;
      logic [31:0] late_total;
      logic [31:0] played_total;
      logic        last;
   } rsp_item_type;

   // one queued frame
   typedef struct packed {
      logic [62:0] due;
      logic [7:0]  handle;
   } slot_type;

   // -------------------------------------------------------------------------
   // Scoreboard: sorted frame queue, counters and the expected result items
   // -------------------------------------------------------------------------
   class playout_scoreboard;
      slot_type     slots[$];
      rsp_item_type expected[$];
      logic [31:0]  late_count;
      logic [31:0]  played_count;
      logic [31:0]  limit_ns;
      int           errors;
      int           reported;

      function new();
         late_count   = '0;
         played_count = '0;
         limit_ns     = LATENESS_RESET;
         errors       = 0;
         reported     = 0;
      endfunction

      function void set_limit(logic [31:0] value);
         limit_ns = value;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      // predict the result items of one accepted request
      function void note_request(req_item_type r);
         rsp_item_type    e;
         slot_type        s;
         longint unsigned due64;
         int              pos;
         if (r.mode == MODE_TICK) begin
            // release every due frame, earliest first
            while (slots.size() > 0 && slots[0].due <= r.now) begin
               s = slots.pop_front();
               played_count++;
               e.kind         = KIND_RELEASED;
               e.handle       = s.handle;
               e.due          = s.due;
               e.level        = 5'(slots.size());
               e.late_total   = late_count;
               e.played_total = played_count;
               e.last         = !(slots.size() > 0 && slots[0].due <= r.now);
               expected.push_back(e);
            end
            return;
         end
         due64    = r.has_ts ? (64'(r.secs) * NS_SEC + 64'(r.nanos)) : 64'(r.now);
         e.handle = r.handle;
         e.due    = due64[62:0];
         e.last   = 1'b1;
         if (r.bytes == 16'd0 || r.bytes[0]) begin
            e.kind = KIND_MALFORMED;
         end else if (64'(e.due) + 64'(limit_ns) < 64'(r.now)) begin
            late_count++;
            e.kind = KIND_LATE;
         end else if (slots.size() >= DEPTH) begin
            e.kind = KIND_FULL;
         end else begin
            // insert after every entry with due <= new due
            pos = slots.size();
            while (pos > 0 && slots[pos-1].due > e.due) pos--;
            s.due    = e.due;
            s.handle = r.handle;
            slots.insert(pos, s);
            e.kind = KIND_ACCEPTED;
         end
         e.level        = 5'(slots.size());
         e.late_total   = late_count;
         e.played_total = played_count;
         expected.push_back(e);
      endfunction

      // compare one received result item with the oldest expectation
      function void check_response(rsp_item_type got);
         rsp_item_type want;
         bit           bad;
         if (expected.size() == 0) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("unexpected result: kind %0d handle %0d due %0d last %0d",
                        got.kind, got.handle, got.due, got.last);
            end
            return;
         end
         want = expected.pop_front();
         bad  = (got.kind !== want.kind) || (got.handle !== want.handle) ||
                (got.due !== want.due) || (got.level !== want.level) ||
                (got.late_total !== want.late_total) ||
                (got.played_total !== want.played_total) || (got.last !== want.last);
         if (bad) begin
            errors++;
            if (reported < 10) begin
               reported++;
               $display("mismatch exp: kind %0d handle %0d due %0d level %0d",
                        want.kind, want.handle, want.due, want.level,
                        " late %0d played %0d last %0d",
                        want.late_total, want.played_total, want.last);
               $display("         got: kind %0d handle %0d due %0d level %0d",
                        got.kind, got.handle, got.due, got.level,
                        " late %0d played %0d last %0d",
                        got.late_total, got.played_total, got.last);
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and DUT
   // -------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // fields from bit 0: now_ns, ts_seconds, ts_nanos, frame_bytes, frame_handle
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // fields from bit 0: mode, has_timestamp
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // fields from bit 0: out_handle, out_due_ns, queue_level, late_total, played_total
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // fields from bit 0: kind
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CNT_W-1:0]      csr_data = '0;

   playout_scoreboard sb;
   logic [62:0]       sim_now;
   logic [31:0]       cur_limit = LATENESS_RESET;
   int                req_free = 0;
   int                rsp_free = 0;
   int                rsp_hold = 0;
   int                cycles = 0;

   timed_playout_queue #(
      .QUEUE_DEPTH(DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Helpers
   // -------------------------------------------------------------------------
   function automatic logic [62:0] rand63();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[62:0];
   endfunction

   // gap length: mostly short, a few long, with stretches of no gaps
   function automatic int pick_gap(inout int free_run);
      int r;
      if (free_run > 0) begin
         free_run--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 6) begin
         free_run = $urandom_range(10, 40);
         return 0;
      end
      if (r < 80) return $urandom_range(0, 2);
      if (r < 95) return $urandom_range(3, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_item_type make_tick(logic [62:0] now);
      req_item_type it;
      it.mode   = MODE_TICK;
      it.now    = now;
      it.has_ts = 1'($urandom_range(0, 1));
      it.secs   = $urandom;
      it.nanos  = 30'($urandom);
      it.bytes  = 16'($urandom);
      it.handle = 8'($urandom);
      return it;
   endfunction

   // enqueue; a stamp that cannot express the due time falls back to none
   function automatic req_item_type build_enqueue(logic [62:0] now, logic has_ts,
                                                  longint unsigned due,
                                                  logic [15:0] bytes,
                                                  logic [7:0] handle);
      req_item_type it;
      it.mode   = MODE_ENQUEUE;
      it.now    = now;
      it.has_ts = has_ts && (due <= TS_MAX);
      it.bytes  = bytes;
      it.handle = handle;
      if (it.has_ts) begin
         it.secs  = 32'(due / NS_SEC);
         it.nanos = 30'(due % NS_SEC);
      end else begin
         it.secs  = $urandom;
         it.nanos = 30'($urandom);
      end
      return it;
   endfunction

   // due time around the present, on both sides of the lateness boundary
   function automatic longint unsigned near_due();
      longint unsigned base;
      longint unsigned back;
      base = 64'(sim_now);
      back = 0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return base + $urandom_range(0, 20000000);
         4, 5:       back = {$urandom, $urandom} % (64'(cur_limit) + 1);
         6:          back = 64'(cur_limit);
         7:          back = 64'(cur_limit) + 1 + $urandom_range(0, 1000000);
         8:          back = 0;
         default:    back = $urandom_range(0, 5000000);
      endcase
      return (back > base) ? 64'd0 : base - back;
   endfunction

   // one random request item
   function automatic req_item_type gen_item();
      req_item_type it;
      int           pick;
      logic [15:0]  len;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         // jump to a new epoch
         sim_now = 63'(({$urandom, $urandom} % 64'd4000000000000000000) + 64'd10000000000);
         return make_tick(sim_now);
      end
      if (pick < 5) return make_tick(NOW_MAX);
      if (pick < 13) begin
         // unshaped noise over the whole field ranges
         it.mode   = 1'($urandom_range(0, 1));
         it.now    = rand63();
         it.has_ts = 1'($urandom_range(0, 1));
         it.secs   = $urandom;
         it.nanos  = 30'($urandom);
         it.bytes  = 16'($urandom);
         it.handle = 8'($urandom);
         return it;
      end
      if (pick < 40) begin
         sim_now = sim_now + $urandom_range(0, 8000000);
         return make_tick(sim_now);
      end
      sim_now = sim_now + $urandom_range(0, 2000000);
      if (pick < 48) begin
         len = ($urandom_range(0, 1) == 0) ? 16'd0 : (16'($urandom) | 16'd1);
      end else begin
         len = ($urandom_range(0, 19) == 0) ? 16'hFFFE : 16'($urandom_range(1, 32767) * 2);
      end
      it = build_enqueue(sim_now, $urandom_range(0, 3) != 0, near_due(), len, 8'($urandom));
      // out of range nanoseconds, added as they are
      if (it.has_ts && $urandom_range(0, 9) == 0) begin
         it.nanos = 30'($urandom_range(1000000000, 1073741823));
      end
      return it;
   endfunction

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   task automatic send_req(req_item_type it);
      int gap;
      gap = pick_gap(req_free);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b0, it.handle, it.bytes, it.nanos, it.secs, it.now};
      req_tuser  <= {it.has_ts, it.mode};
      do @(posedge clock); while (!req_tready);
      sb.note_request(it);
   endtask

   task automatic wait_drained(int extra);
      while (sb.pending() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // rewrite the lateness limit while the block is idle
   task automatic write_limit(logic [31:0] value);
      req_tvalid <= 1'b0;
      wait_drained(SETTLE_CYCLES);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_limit(value);
      cur_limit = value;
   endtask

   // directed items with the reset lateness limit
   task automatic run_directed();
      logic [62:0]  t;
      req_item_type it;
      int           k;
      t       = 63'd5000000000;
      sim_now = t;
      // tick on an empty queue: nothing due
      send_req(make_tick(63'd0));
      // no timestamp: due is now
      send_req(build_enqueue(t, 1'b0, 0, 16'd2, 8'd0));
      // malformed zero length still reports its due time, nanos out of range
      it = build_enqueue(t, 1'b1, t + 1000, 16'd0, 8'd17);
      it.nanos = 30'h3FFFFFFF;
      send_req(it);
      // malformed odd length
      send_req(build_enqueue(t, 1'b1, t, 16'hFFFF, 8'hFF));
      // one past the lateness limit, then exactly at it
      send_req(build_enqueue(t, 1'b1, t - LATENESS_RESET - 1, 16'd100, 8'd3));
      send_req(build_enqueue(t, 1'b1, t - LATENESS_RESET, 16'd100, 8'd4));
      // nanoseconds above one second, accepted as they are
      it = build_enqueue(t, 1'b1, t, 16'hFFFE, 8'd5);
      it.secs  = 32'd5;
      it.nanos = 30'h3FFFFFFF;
      send_req(it);
      // equal due times keep arrival order
      send_req(build_enqueue(t, 1'b1, t, 16'd2, 8'd6));
      send_req(build_enqueue(t, 1'b0, 0, 16'd4, 8'd7));
      // fill with descending due times, each walks back through the queue
      for (k = 0; k < DEPTH - 5; k++)
         send_req(build_enqueue(t, 1'b1, t + (20 - k) * 1000000, 16'd64, 8'(20 + k)));
      // queue full
      send_req(build_enqueue(t, 1'b1, t + 30000000, 16'd64, 8'd99));
      // release everything
      send_req(make_tick(NOW_MAX));
      // largest stamp at the latest time is late
      send_req(build_enqueue(NOW_MAX, 1'b1, TS_MAX, 16'd8, 8'd200));
      // largest due time, then released
      send_req(build_enqueue(NOW_MAX, 1'b0, 0, 16'd8, 8'd201));
      send_req(make_tick(NOW_MAX));
      sim_now = 63'd10000000000;
   endtask

   // -------------------------------------------------------------------------
   // Result side: random stalls and checking
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 2) == 0) rsp_hold = pick_gap(rsp_free);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response('{kind: rsp_tuser, handle: rsp_tdata[7:0], due: rsp_tdata[70:8],
                             level: rsp_tdata[75:71], late_total: rsp_tdata[107:76],
                             played_total: rsp_tdata[139:108], last: rsp_tlast});
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timed_playout_queue test failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [31:0] limits[5];
      int          p;
      int          n;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      // zero, largest, random, small random, then back to the reset value
      limits[0] = 32'd0;
      limits[1] = 32'hFFFFFFFF;
      limits[2] = $urandom;
      limits[3] = $urandom_range(1, 2000);
      limits[4] = LATENESS_RESET;
      for (p = 0; p < 5; p++) begin
         write_limit(limits[p]);
         for (n = 0; n < PHASE_ITEMS; n++) send_req(gen_item());
      end
      req_tvalid <= 1'b0;
      wait_drained(SETTLE_CYCLES + 12);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("timed_playout_queue test passed");
      end else begin
         $display("timed_playout_queue test failed");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/tpq_pkg.sv
sv/tpq_ram.sv
sv/tpq_ctrl.sv
sv/tpq_dp.sv
sv/timed_playout_queue.sv
verif/timed_playout_queue_tb.sv
